// ----- hdl/pcm_pkg.sv -----
// shared types and constants for the pedal command map
`default_nettype none

package pcm_pkg;

    typedef enum logic [1:0] {
        SEG_ACCEL = 2'd0,
        SEG_COAST = 2'd1,
        SEG_BRAKE = 2'd2
    } seg_t;

    localparam logic REQ_CMD_TO_MV = 1'b0;
    localparam logic REQ_MV_TO_CMD = 1'b1;

    localparam int CFG_IDX_BITS = 3;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_BRAKE_FULL_MV   = 3'd0;
    localparam cfg_idx_t CFG_BRAKE_START_MV  = 3'd1;
    localparam cfg_idx_t CFG_GAS_START_MV    = 3'd2;
    localparam cfg_idx_t CFG_GAS_FULL_MV     = 3'd3;
    localparam cfg_idx_t CFG_BRAKE_START_CMD = 3'd4;
    localparam cfg_idx_t CFG_GAS_START_CMD   = 3'd5;

    localparam int BRAKE_FULL_MV_RST   = 500;
    localparam int BRAKE_START_MV_RST  = 2000;
    localparam int GAS_START_MV_RST    = 3000;
    localparam int GAS_FULL_MV_RST     = 4500;
    localparam int BRAKE_START_CMD_RST = -3277;
    localparam int GAS_START_CMD_RST   = 3277;

endpackage

`default_nettype wire

// ----- hdl/pcm_if.sv -----
// request and result channel interfaces of the pedal command map
`default_nettype none

interface pcm_in_if #(
    parameter int CMD_BITS = 16,
    parameter int MV_BITS  = 13
) ();
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic signed [CMD_BITS-1:0] command_in;
    logic [MV_BITS-1:0]         millivolts_in;

    modport source (output valid, output req_type, output command_in,
                    output millivolts_in, input ready);
    modport sink   (input valid, input req_type, input command_in,
                    input millivolts_in, output ready);
endinterface

interface pcm_out_if #(
    parameter int CMD_BITS = 16,
    parameter int MV_BITS  = 13
) ();
    logic                       valid;
    logic                       ready;
    logic [MV_BITS-1:0]         millivolts_out;
    logic signed [CMD_BITS-1:0] command_out;
    logic [1:0]                 segment;
    logic                       clamped;

    modport source (output valid, output millivolts_out, output command_out,
                    output segment, output clamped, input ready);
    modport sink   (input valid, input millivolts_out, input command_out,
                    input segment, input clamped, output ready);
endinterface

`default_nettype wire

// ----- hdl/pcm_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with sideband
`default_nettype none

module pcm_div #(
    parameter int NW = 34,
    parameter int DW = 17,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          v_reg   [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] nq_reg  [NW];
    logic [DW-1:0] d_reg   [NW];
    logic [SW-1:0] sd_reg  [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [NW-1:0] nq_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] sd_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] nq_next;

        if (i == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = '0;
            assign nq_in  = num;
            assign d_in   = den;
            assign sd_in  = side_in;
        end else begin : g_rest
            assign v_in   = v_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign d_in   = d_reg[i-1];
            assign sd_in  = sd_reg[i-1];
        end

        always_comb
        begin
            trial    = {rem_in, nq_in[NW-1]};
            diff     = trial - {1'b0, d_in};
            ge       = (trial >= {1'b0, d_in});
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            nq_next  = {nq_in[NW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                nq_reg[i]  <= nq_next;
                d_reg[i]   <= d_in;
                sd_reg[i]  <= sd_in;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quo       = nq_reg[NW-1];
    assign side_out  = sd_reg[NW-1];

endmodule

`default_nettype wire

// ----- hdl/pedal_command_piecewise_map_top.sv -----
// top level of the pedal command map: three-segment command/millivolt conversion
//
// item_in carries req_type, command_in and millivolts_in; req_type 0 maps the
// Q-format command to actuator millivolts, req_type 1 maps millivolts (clamped
// to the configured range) back to a command. item_out carries one result item
// per request: millivolts_out, command_out, segment and clamped.
// The breakpoint registers are written through cfg_we/cfg_index/cfg_data. The
// user must write them only while no item is in flight; the block itself does
// not enforce this. Throughput is one item per cycle while the skid register is
// empty. Each item passes the select, operand, magnitude and multiply stages,
// the divider, which resolves one quotient bit per stage, and the sum and
// output stages. Reset clears all valid bits and loads the breakpoint registers
// with their default map. When the receiver stalls, the output register holds
// its item and one more item lands in a skid register; the whole pipeline then
// freezes and item_in.ready stays low until the skid register drains.
`default_nettype none

module pedal_command_piecewise_map_top #(
    parameter int CMD_FRAC_BITS = 15,
    parameter int MV_BITS       = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    pcm_in_if.sink           item_in,
    pcm_out_if.source        item_out,
    input  logic             cfg_we,
    input  pcm_pkg::cfg_idx_t cfg_index,
    input  logic [((CMD_FRAC_BITS+1 > MV_BITS) ? CMD_FRAC_BITS+1 : MV_BITS)-1:0] cfg_data
);

    import pcm_pkg::*;

    localparam int CB  = CMD_FRAC_BITS + 1;
    localparam int MB  = MV_BITS;
    localparam int CW  = CB + 2;
    localparam int OW  = (CW > MB + 1) ? CW : MB + 1;
    localparam int MW  = OW - 1;
    localparam int PW  = 2 * MW;
    localparam int RW  = PW + 2;

    localparam logic signed [OW-1:0] ONE_W     = OW'(1) << CMD_FRAC_BITS;
    localparam logic signed [RW-1:0] ONE_R     = RW'(1) << CMD_FRAC_BITS;
    localparam logic signed [RW-1:0] CMD_TOP_R = ONE_R - RW'(1);
    localparam logic signed [RW-1:0] MV_TOP_R  = (RW'(1) << MB) - RW'(1);

    typedef struct packed {
        logic                  req;
        seg_t                  seg;
        logic                  clamp;
        logic                  neg;
        logic                  zero;
        logic signed [OW-1:0]  base;
    } side_t;

    typedef struct packed {
        logic                  req;
        logic [MB-1:0]         mv;
        logic signed [CB-1:0]  cmd;
        seg_t                  seg;
        logic                  clamp;
    } res_t;

    // breakpoint registers
    logic [MB-1:0]        bf_reg, bsm_reg, gsm_reg, gf_reg;
    logic signed [CB-1:0] bsc_reg, gsc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bf_reg  <= MB'(BRAKE_FULL_MV_RST);
            bsm_reg <= MB'(BRAKE_START_MV_RST);
            gsm_reg <= MB'(GAS_START_MV_RST);
            gf_reg  <= MB'(GAS_FULL_MV_RST);
            bsc_reg <= CB'(BRAKE_START_CMD_RST);
            gsc_reg <= CB'(GAS_START_CMD_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BRAKE_FULL_MV:   bf_reg  <= cfg_data[MB-1:0];
                CFG_BRAKE_START_MV:  bsm_reg <= cfg_data[MB-1:0];
                CFG_GAS_START_MV:    gsm_reg <= cfg_data[MB-1:0];
                CFG_GAS_FULL_MV:     gf_reg  <= cfg_data[MB-1:0];
                CFG_BRAKE_START_CMD: bsc_reg <= cfg_data[CB-1:0];
                CFG_GAS_START_CMD:   gsc_reg <= cfg_data[CB-1:0];
                default:             ;
            endcase
        end
    end

    logic signed [OW-1:0] bf_w, bsm_w, gsm_w, gf_w, bs_w, gs_w;

    assign bf_w  = {{(OW-MB){1'b0}}, bf_reg};
    assign bsm_w = {{(OW-MB){1'b0}}, bsm_reg};
    assign gsm_w = {{(OW-MB){1'b0}}, gsm_reg};
    assign gf_w  = {{(OW-MB){1'b0}}, gf_reg};
    assign bs_w  = {{(OW-CB){bsc_reg[CB-1]}}, bsc_reg};
    assign gs_w  = {{(OW-CB){gsc_reg[CB-1]}}, gsc_reg};

    // pipeline advance, frozen while the skid register holds an item
    logic adv;
    logic k_v_reg;

    assign adv           = !k_v_reg;
    assign item_in.ready = adv;

    // stage 1: clamp and segment select
    logic signed [OW-1:0] c_w, m_w, mc_w;
    logic signed [OW-1:0] s1_val_next;
    seg_t                 s1_seg_next;
    logic                 s1_clamp_next;

    logic                 s1_v_reg;
    logic                 s1_req_reg;
    logic signed [OW-1:0] s1_val_reg;
    seg_t                 s1_seg_reg;
    logic                 s1_clamp_reg;

    always_comb
    begin
        c_w           = {{(OW-CB){item_in.command_in[CB-1]}}, item_in.command_in};
        m_w           = {{(OW-MB){1'b0}}, item_in.millivolts_in};
        mc_w          = m_w;
        s1_clamp_next = 1'b0;
        if (m_w < bf_w)
        begin
            mc_w          = bf_w;
            s1_clamp_next = 1'b1;
        end
        else if (m_w > gf_w)
        begin
            mc_w          = gf_w;
            s1_clamp_next = 1'b1;
        end
        if (item_in.req_type == REQ_CMD_TO_MV)
        begin
            s1_val_next   = c_w;
            s1_clamp_next = 1'b0;
            if (c_w >= gs_w)
                s1_seg_next = SEG_ACCEL;
            else if (c_w > bs_w)
                s1_seg_next = SEG_COAST;
            else
                s1_seg_next = SEG_BRAKE;
        end
        else
        begin
            s1_val_next = mc_w;
            if (mc_w >= gsm_w)
                s1_seg_next = SEG_ACCEL;
            else if (mc_w > bsm_w)
                s1_seg_next = SEG_COAST;
            else
                s1_seg_next = SEG_BRAKE;
        end
    end

    // stage 2: segment operands
    logic signed [OW-1:0] s2_a_next, s2_b_next, s2_den_next, s2_base_next;
    logic                 s2_sub_next;

    logic                 s2_v_reg;
    logic                 s2_req_reg;
    seg_t                 s2_seg_reg;
    logic                 s2_clamp_reg;
    logic                 s2_sub_reg;
    logic signed [OW-1:0] s2_a_reg, s2_b_reg, s2_den_reg, s2_base_reg;

    always_comb
    begin
        s2_sub_next = 1'b0;
        if (s1_req_reg == REQ_CMD_TO_MV)
        begin
            case (s1_seg_reg)
                SEG_ACCEL:
                begin
                    s2_a_next    = s1_val_reg - gs_w;
                    s2_b_next    = gf_w - gsm_w;
                    s2_den_next  = ONE_W - gs_w;
                    s2_base_next = gsm_w;
                end
                SEG_COAST:
                begin
                    s2_a_next    = s1_val_reg - bs_w;
                    s2_b_next    = gsm_w - bsm_w;
                    s2_den_next  = gs_w - bs_w;
                    s2_base_next = bsm_w;
                end
                default:
                begin
                    s2_a_next    = bs_w - s1_val_reg;
                    s2_b_next    = bsm_w - bf_w;
                    s2_den_next  = bs_w + ONE_W;
                    s2_base_next = bsm_w;
                    s2_sub_next  = 1'b1;
                end
            endcase
        end
        else
        begin
            case (s1_seg_reg)
                SEG_ACCEL:
                begin
                    s2_a_next    = s1_val_reg - gsm_w;
                    s2_b_next    = ONE_W - gs_w;
                    s2_den_next  = gf_w - gsm_w;
                    s2_base_next = gs_w;
                end
                SEG_COAST:
                begin
                    s2_a_next    = s1_val_reg - bsm_w;
                    s2_b_next    = gs_w - bs_w;
                    s2_den_next  = gsm_w - bsm_w;
                    s2_base_next = bs_w;
                end
                default:
                begin
                    s2_a_next    = bsm_w - s1_val_reg;
                    s2_b_next    = bs_w + ONE_W;
                    s2_den_next  = bsm_w - bf_w;
                    s2_base_next = bs_w;
                    s2_sub_next  = 1'b1;
                end
            endcase
        end
    end

    // stage 3: magnitudes and result sign
    logic signed [OW-1:0] a_abs, b_abs, d_abs;
    side_t                s3_side_next;

    logic                 s3_v_reg;
    logic [MW-1:0]        s3_am_reg, s3_bm_reg, s3_dm_reg;
    side_t                s3_side_reg;

    always_comb
    begin
        a_abs              = s2_a_reg[OW-1] ? -s2_a_reg : s2_a_reg;
        b_abs              = s2_b_reg[OW-1] ? -s2_b_reg : s2_b_reg;
        d_abs              = s2_den_reg[OW-1] ? -s2_den_reg : s2_den_reg;
        s3_side_next.req   = s2_req_reg;
        s3_side_next.seg   = s2_seg_reg;
        s3_side_next.clamp = s2_clamp_reg;
        s3_side_next.neg   = s2_a_reg[OW-1] ^ s2_b_reg[OW-1] ^ s2_den_reg[OW-1]
                             ^ s2_sub_reg;
        s3_side_next.zero  = (s2_den_reg == '0);
        s3_side_next.base  = s2_base_reg;
    end

    // stage 4: product
    logic                 s4_v_reg;
    logic [PW-1:0]        s4_prod_reg;
    logic [MW-1:0]        s4_dm_reg;
    side_t                s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= item_in.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_req_reg   <= item_in.req_type;
            s1_val_reg   <= s1_val_next;
            s1_seg_reg   <= s1_seg_next;
            s1_clamp_reg <= s1_clamp_next;

            s2_req_reg   <= s1_req_reg;
            s2_seg_reg   <= s1_seg_reg;
            s2_clamp_reg <= s1_clamp_reg;
            s2_sub_reg   <= s2_sub_next;
            s2_a_reg     <= s2_a_next;
            s2_b_reg     <= s2_b_next;
            s2_den_reg   <= s2_den_next;
            s2_base_reg  <= s2_base_next;

            s3_am_reg    <= a_abs[MW-1:0];
            s3_bm_reg    <= b_abs[MW-1:0];
            s3_dm_reg    <= d_abs[MW-1:0];
            s3_side_reg  <= s3_side_next;

            s4_prod_reg  <= PW'(s3_am_reg) * PW'(s3_bm_reg);
            s4_dm_reg    <= s3_dm_reg;
            s4_side_reg  <= s3_side_reg;
        end
    end

    // quotient magnitude
    logic                   dv_v;
    logic [PW-1:0]          dv_quo;
    logic [$bits(side_t)-1:0] dv_side_vec;
    side_t                  dv_side;

    pcm_div #(
        .NW (PW),
        .DW (MW),
        .SW ($bits(side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s4_v_reg),
        .num       (s4_prod_reg),
        .den       (s4_dm_reg),
        .side_in   (s4_side_reg),
        .out_valid (dv_v),
        .quo       (dv_quo),
        .side_out  (dv_side_vec)
    );

    assign dv_side = dv_side_vec;

    // sum stage
    logic signed [RW-1:0] q_r, base_r, sum_next;
    logic                 sum_v_reg;
    logic signed [RW-1:0] sum_reg;
    logic                 sum_req_reg;
    seg_t                 sum_seg_reg;
    logic                 sum_clamp_reg;

    always_comb
    begin
        q_r      = dv_side.zero ? '0 : {2'b00, dv_quo};
        base_r   = {{(RW-OW){dv_side.base[OW-1]}}, dv_side.base};
        sum_next = dv_side.neg ? base_r - q_r : base_r + q_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            sum_v_reg <= dv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg       <= sum_next;
            sum_req_reg   <= dv_side.req;
            sum_seg_reg   <= dv_side.seg;
            sum_clamp_reg <= dv_side.clamp;
        end
    end

    // saturation into the output register
    res_t x_res;

    always_comb
    begin
        x_res.req   = sum_req_reg;
        x_res.seg   = sum_seg_reg;
        x_res.clamp = sum_clamp_reg;
        x_res.mv    = '0;
        x_res.cmd   = '0;
        if (sum_req_reg == REQ_CMD_TO_MV)
        begin
            if (sum_reg < 0)
                x_res.mv = '0;
            else if (sum_reg > MV_TOP_R)
                x_res.mv = MV_TOP_R[MB-1:0];
            else
                x_res.mv = sum_reg[MB-1:0];
        end
        else
        begin
            if (sum_reg < -ONE_R)
                x_res.cmd = -ONE_R[CB-1:0];
            else if (sum_reg > CMD_TOP_R)
                x_res.cmd = CMD_TOP_R[CB-1:0];
            else
                x_res.cmd = sum_reg[CB-1:0];
        end
    end

    // output register and skid
    logic o_v_reg, o_v_next, k_v_next;
    res_t o_res_reg, o_res_next, k_res_reg, k_res_next;

    always_comb
    begin
        o_v_next   = o_v_reg;
        k_v_next   = k_v_reg;
        o_res_next = o_res_reg;
        k_res_next = k_res_reg;
        if (o_v_reg && !item_out.ready)
        begin
            if (adv && sum_v_reg)
            begin
                k_v_next   = 1'b1;
                k_res_next = x_res;
            end
        end
        else if (k_v_reg)
        begin
            o_v_next   = 1'b1;
            o_res_next = k_res_reg;
            k_v_next   = 1'b0;
        end
        else
        begin
            o_v_next   = sum_v_reg;
            o_res_next = x_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
            k_v_reg <= 1'b0;
        end
        else
        begin
            o_v_reg <= o_v_next;
            k_v_reg <= k_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_res_reg <= o_res_next;
        k_res_reg <= k_res_next;
    end

    assign item_out.valid          = o_v_reg;
    assign item_out.millivolts_out = o_res_reg.mv;
    assign item_out.command_out    = o_res_reg.cmd;
    assign item_out.segment        = o_res_reg.seg;
    assign item_out.clamped        = o_res_reg.clamp;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        k_v_reg |-> o_v_reg)
        else $error("skid register holds an item while the output is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(k_v_reg) |-> $past(o_v_reg && !item_out.ready))
        else $error("skid register loaded without an output stall");

    a_mv_req_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (o_v_reg && o_res_reg.req == REQ_CMD_TO_MV)
        |-> (o_res_reg.cmd == '0 && !o_res_reg.clamp))
        else $error("command-to-millivolt result carries command or clamp");

    a_cmd_req_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (o_v_reg && o_res_reg.req == REQ_MV_TO_CMD) |-> (o_res_reg.mv == '0))
        else $error("millivolt-to-command result carries millivolts");

    a_accept_captured: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_in.ready) |=> s1_v_reg)
        else $error("accepted item not captured by the first stage");
`endif

endmodule

`default_nettype wire
